@@ hw/rtl/smsf_pkg.sv @@
// ----------------------------------------------------------------------------
// smsf_pkg: shared types and constants of the stereo mixer
// Codes, control structs and fixed field widths used by the mixer and its
// sequencer and multiply-accumulate unit.
// ----------------------------------------------------------------------------
package smsf_pkg;

   // Gain format: unsigned Q2.14, limited to 2.0
   localparam int GAIN_W = 16;
   localparam int GAIN_EXT_W = GAIN_W + 1;
   localparam int GAIN_SHIFT = 14;
   localparam logic [GAIN_W-1:0] GAIN_MAX = 16'd32768;
   localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd16384;

   // Fixed field widths
   localparam int DROP_W = 32;
   localparam int SRC_FIELD_W = 2;
   localparam int NPROC_W = 2;

   // Register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_MIC_GAIN     = 2'd0,
      REG_PROC_GAIN    = 2'd1,
      REG_PROC_SOURCES = 2'd2
   } reg_index_type;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_PULL = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_READ,
      ST_MUL_L,
      ST_MUL_R,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Sequencer to multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic mul_en;
      logic sel_right;
   } mac_ctrl_type;

   // Sequencer to output register
   typedef struct packed {
      logic              load;
      logic              is_pull;
      logic              dropped;
      logic              underrun;
      logic [DROP_W-1:0] total;
   } result_type;

endpackage

@@ hw/rtl/smsf_frame_store.sv @@
// ----------------------------------------------------------------------------
// smsf_frame_store: frame memory of all source FIFOs
// One write port and one read port with registered read data. Entries hold
// a left and right sample side by side and are undefined until written.
// ----------------------------------------------------------------------------
module smsf_frame_store #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 48
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];
   logic [DATA_W-1:0] rd_data_ff;

   // Store a frame
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Fetch a frame, hold it until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/smsf_mac.sv @@
// ----------------------------------------------------------------------------
// smsf_mac: shared multiply-accumulate unit of the mixer
// One sample by gain multiplier, registered, feeding a left and a right
// accumulator. Accumulators start at the rounding bias, so the final value
// only needs a shift and a clamp to full scale.
// ----------------------------------------------------------------------------
module smsf_mac #(
   parameter int SAMPLE_BITS = 24,
   parameter int SRC_W = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  smsf_pkg::mac_ctrl_type            ctrl,
   input  logic signed [SAMPLE_BITS-1:0]     sample,
   input  logic [smsf_pkg::GAIN_W-1:0]       gain,
   output logic signed [SAMPLE_BITS-1:0]     mix_left,
   output logic signed [SAMPLE_BITS-1:0]     mix_right
);

   localparam int PROD_W = SAMPLE_BITS + smsf_pkg::GAIN_EXT_W;
   localparam int ACC_W = PROD_W + SRC_W;
   localparam int Q_W = ACC_W - smsf_pkg::GAIN_SHIFT;
   localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(2 ** (smsf_pkg::GAIN_SHIFT - 1));

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic                     add_ff;
   logic                     sel_ff;
   logic [ACC_W-1:0]         acc_l_ff;
   logic [ACC_W-1:0]         acc_r_ff;
   logic [ACC_W-1:0]         acc_l_in;
   logic [ACC_W-1:0]         acc_r_in;
   logic [ACC_W-1:0]         prod_ext;

   // Round down by the gain shift and clamp to the sample range
   function automatic logic [SAMPLE_BITS-1:0] clamp_sample(input logic [ACC_W-1:0] acc);
      logic [Q_W-1:0]             q;
      logic [Q_W-SAMPLE_BITS:0]   head;
      logic [SAMPLE_BITS-1:0]     res;
      q = acc[ACC_W-1:smsf_pkg::GAIN_SHIFT];
      head = q[Q_W-1:SAMPLE_BITS-1];
      if (head == '0 || head == '1) begin
         res = q[SAMPLE_BITS-1:0];
      end else if (q[Q_W-1]) begin
         res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
      return res;
   endfunction

   // Multiply one sample by its gain
   assign prod_in = sample * $signed({1'b0, gain});
   assign prod_ext = {{SRC_W{prod_ff[PROD_W-1]}}, prod_ff};

   // Delay the add strobe and channel select by the multiplier register
   always_ff @(posedge clock) begin
      if (reset) begin
         add_ff <= 1'b0;
         sel_ff <= 1'b0;
      end else begin
         add_ff <= ctrl.mul_en;
         sel_ff <= ctrl.sel_right;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // Preload the bias or add the product into the selected channel
   always_comb begin
      acc_l_in = acc_l_ff;
      acc_r_in = acc_r_ff;
      if (ctrl.clear) begin
         acc_l_in = ROUND_BIAS;
         acc_r_in = ROUND_BIAS;
      end else if (add_ff) begin
         if (sel_ff) begin
            acc_r_in = acc_r_ff + prod_ext;
         end else begin
            acc_l_in = acc_l_ff + prod_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_l_ff <= acc_l_in;
      acc_r_ff <= acc_r_in;
   end

   assign mix_left = clamp_sample(acc_l_ff);
   assign mix_right = clamp_sample(acc_r_ff);

endmodule

@@ hw/rtl/smsf_seq.sv @@
// ----------------------------------------------------------------------------
// smsf_seq: command sequencer and FIFO bookkeeping
// Keeps read and write indices, fill levels and drop counters per source,
// runs a push in one step and walks a pull source by source through the
// frame store and the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
module smsf_seq #(
   parameter int FIFO_DEPTH = 1024,
   parameter int NUM_SOURCES = 4,
   parameter int SAMPLE_BITS = 24,
   localparam int SRC_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1,
   localparam int IDX_W = $clog2(FIFO_DEPTH)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  in_ready,
   input  logic                                  req_cmd,
   input  logic [smsf_pkg::SRC_FIELD_W-1:0]      req_source,
   input  logic signed [SAMPLE_BITS-1:0]         req_in_left,
   input  logic signed [SAMPLE_BITS-1:0]         req_in_right,
   input  logic [SRC_W-1:0]                      nproc,
   input  logic [smsf_pkg::GAIN_W-1:0]           mic_gain,
   input  logic [smsf_pkg::GAIN_W-1:0]           proc_gain,
   input  logic                                  out_free,
   output logic                                  mem_we,
   output logic [SRC_W+IDX_W-1:0]                mem_waddr,
   output logic [2*SAMPLE_BITS-1:0]              mem_wdata,
   output logic                                  mem_re,
   output logic [SRC_W+IDX_W-1:0]                mem_raddr,
   input  logic [2*SAMPLE_BITS-1:0]              mem_rdata,
   output smsf_pkg::mac_ctrl_type                mac_ctrl,
   output logic signed [SAMPLE_BITS-1:0]         mac_sample,
   output logic [smsf_pkg::GAIN_W-1:0]           mac_gain,
   output smsf_pkg::result_type                  result
);

   localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FIFO_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FIFO_DEPTH);

   smsf_pkg::state_type state_ff;
   smsf_pkg::state_type state_in;

   logic                           accept;
   logic                           cmd_ff;
   logic                           push_ok_ff;
   logic [SRC_W-1:0]               src_ff;
   logic [SAMPLE_BITS-1:0]         left_ff;
   logic [SAMPLE_BITS-1:0]         right_ff;
   logic                           have_ff;
   logic                           under_ff;
   logic                           dropped_ff;
   logic [smsf_pkg::DROP_W-1:0]    total_ff;
   logic [IDX_W-1:0]               rd_idx_ff [NUM_SOURCES];
   logic [IDX_W-1:0]               wr_idx_ff [NUM_SOURCES];
   logic [FILL_W-1:0]              fill_ff [NUM_SOURCES];
   logic [smsf_pkg::DROP_W-1:0]    drop_ff [NUM_SOURCES];
   logic                           cur_empty;
   logic                           cur_full;
   logic [smsf_pkg::DROP_W-1:0]    drop_next;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
      return (idx == IDX_LAST) ? '0 : idx + 1'b1;
   endfunction

   assign accept = req_valid && in_ready;
   assign cur_empty = (fill_ff[src_ff] == '0);
   assign cur_full = (fill_ff[src_ff] == FILL_FULL);
   assign drop_next = (drop_ff[src_ff] == '1) ? drop_ff[src_ff] : drop_ff[src_ff] + 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         smsf_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_cmd == smsf_pkg::CMD_PULL) ? smsf_pkg::ST_READ
                                                          : smsf_pkg::ST_PUSH;
            end
         end
         smsf_pkg::ST_PUSH:  state_in = smsf_pkg::ST_DONE;
         smsf_pkg::ST_READ:  state_in = smsf_pkg::ST_MUL_L;
         smsf_pkg::ST_MUL_L: state_in = smsf_pkg::ST_MUL_R;
         smsf_pkg::ST_MUL_R: begin
            state_in = (src_ff == nproc) ? smsf_pkg::ST_DRAIN : smsf_pkg::ST_READ;
         end
         smsf_pkg::ST_DRAIN: state_in = smsf_pkg::ST_DONE;
         smsf_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = smsf_pkg::ST_IDLE;
            end
         end
         default: state_in = smsf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smsf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs of the sequencer
   always_comb begin
      in_ready = 1'b0;
      mem_we = 1'b0;
      mem_re = 1'b0;
      mac_ctrl = '0;
      result.load = 1'b0;
      result.is_pull = (cmd_ff == smsf_pkg::CMD_PULL);
      result.dropped = dropped_ff;
      result.underrun = under_ff;
      result.total = total_ff;
      unique case (state_ff)
         smsf_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            mac_ctrl.clear = 1'b1;
         end
         smsf_pkg::ST_PUSH:  mem_we = push_ok_ff && !cur_full;
         smsf_pkg::ST_READ:  mem_re = !cur_empty;
         smsf_pkg::ST_MUL_L: mac_ctrl.mul_en = 1'b1;
         smsf_pkg::ST_MUL_R: begin
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.sel_right = 1'b1;
         end
         smsf_pkg::ST_DRAIN: begin
         end
         smsf_pkg::ST_DONE:  result.load = out_free;
         default: begin
         end
      endcase
   end

   assign mem_waddr = {src_ff, wr_idx_ff[src_ff]};
   assign mem_raddr = {src_ff, rd_idx_ff[src_ff]};
   assign mem_wdata = {left_ff, right_ff};

   // Feed the multiplier; an empty source gives silence
   always_comb begin
      mac_sample = '0;
      if (have_ff) begin
         mac_sample = (state_ff == smsf_pkg::ST_MUL_R) ? mem_rdata[SAMPLE_BITS-1:0]
                                                        : mem_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      end
   end

   assign mac_gain = (src_ff == '0) ? mic_gain : proc_gain;

   // Latch the beat and step through the sources
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff <= smsf_pkg::CMD_PUSH;
         push_ok_ff <= 1'b0;
         src_ff <= '0;
         left_ff <= '0;
         right_ff <= '0;
         have_ff <= 1'b0;
         under_ff <= 1'b0;
         dropped_ff <= 1'b0;
         total_ff <= '0;
      end else begin
         if (accept) begin
            cmd_ff <= req_cmd;
            push_ok_ff <= (32'(req_source) < NUM_SOURCES);
            src_ff <= (req_cmd == smsf_pkg::CMD_PULL) ? '0 : SRC_W'(req_source);
            left_ff <= req_in_left;
            right_ff <= req_in_right;
            under_ff <= 1'b0;
            dropped_ff <= 1'b0;
            total_ff <= '0;
         end
         if (state_ff == smsf_pkg::ST_READ) begin
            have_ff <= !cur_empty;
            if (cur_empty) begin
               under_ff <= 1'b1;
            end
         end
         if (state_ff == smsf_pkg::ST_MUL_R && src_ff != nproc) begin
            src_ff <= src_ff + 1'b1;
         end
         if (state_ff == smsf_pkg::ST_PUSH && push_ok_ff) begin
            if (cur_full) begin
               dropped_ff <= 1'b1;
               total_ff <= drop_next;
            end else begin
               total_ff <= drop_ff[src_ff];
            end
         end
      end
   end

   // Per-source FIFO indices, fill levels and drop counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SOURCES; i++) begin
            rd_idx_ff[i] <= '0;
            wr_idx_ff[i] <= '0;
            fill_ff[i] <= '0;
            drop_ff[i] <= '0;
         end
      end else begin
         if (mem_re) begin
            rd_idx_ff[src_ff] <= next_idx(rd_idx_ff[src_ff]);
            fill_ff[src_ff] <= fill_ff[src_ff] - 1'b1;
         end
         if (mem_we) begin
            wr_idx_ff[src_ff] <= next_idx(wr_idx_ff[src_ff]);
            fill_ff[src_ff] <= fill_ff[src_ff] + 1'b1;
         end
         if (state_ff == smsf_pkg::ST_PUSH && push_ok_ff && cur_full) begin
            drop_ff[src_ff] <= drop_next;
         end
      end
   end

   // An accepted beat always starts work
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != smsf_pkg::ST_IDLE)
      else $error("accepted beat left the sequencer idle");

   // A finished result holds while the output register is occupied
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == smsf_pkg::ST_DONE && !out_free) |=>
         (state_ff == smsf_pkg::ST_DONE && $stable(total_ff) && $stable(under_ff)))
      else $error("result changed while waiting for the output register");

   // A frame fetch is followed by its left multiply with valid data
   a_read_then_mul: assert property (@(posedge clock) disable iff (reset)
      mem_re |=> (state_ff == smsf_pkg::ST_MUL_L && have_ff))
      else $error("fetched frame not multiplied");

   // A push result never reports underrun, a pull result never a drop
   a_flag_kind: assert property (@(posedge clock) disable iff (reset)
      result.load |-> (result.is_pull ? !result.dropped : !result.underrun))
      else $error("status flag on the wrong command");

endmodule

@@ hw/rtl/stereo_mixer_with_source_fifos.sv @@
// ----------------------------------------------------------------------------
// stereo_mixer_with_source_fifos: stereo mixer with a frame FIFO per source
// Source 0 is the microphone, the others are process captures. Push beats
// store frames, pull beats pop and mix one frame from each active source.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command beat: push (store req_in_left/right into the
//   FIFO of req_source) or pull (mix one frame). rsp_* returns one beat per
//   command: the clamped mix on a pull, or the drop flag and the source's
//   saturating drop count on a push. A full FIFO drops the pushed frame; an
//   empty FIFO on pull contributes silence and raises rsp_underrun.
//   Gains and the number of mixed process sources sit in the configuration
//   registers (mic_gain at 0x0, proc_gain at 0x4, process_sources at 0x8).
// Sequencing:
//   A push stores its frame in one step and then loads the output register;
//   a pull with n process sources does, per source, a frame fetch and two
//   multiplies on the single shared multiplier, then drains the last product
//   and loads the output register. The next command is accepted in the cycle
//   after the result loads, so no new command is taken while one is in work.
//   A result may wait in the output register under rsp_stall while new work
//   goes on; a further result waits in the sequencer with req_stall high.
// Reset:
//   All FIFOs empty, drop counters zero, gains 1.0, process_sources 0. Frame
//   storage is not cleared, so the block is ready right after reset.
// ----------------------------------------------------------------------------
module stereo_mixer_with_source_fifos #(
   parameter int FIFO_DEPTH = 1024,
   parameter int NUM_SOURCES = 4,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Command channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic [smsf_pkg::SRC_FIELD_W-1:0]      req_source,
   input  logic signed [SAMPLE_BITS-1:0]         req_in_left,
   input  logic signed [SAMPLE_BITS-1:0]         req_in_right,
   // Result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]         rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0]         rsp_out_right,
   output logic                                  rsp_dropped,
   output logic                                  rsp_underrun,
   output logic [smsf_pkg::DROP_W-1:0]           rsp_drop_total,
   // Register port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [smsf_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [smsf_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [smsf_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);

   localparam int SRC_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
   localparam int IDX_W = $clog2(FIFO_DEPTH);
   localparam int MEM_AW = SRC_W + IDX_W;
   localparam int FRAME_W = 2 * SAMPLE_BITS;

   logic [smsf_pkg::GAIN_W-1:0]   mic_gain_ff;
   logic [smsf_pkg::GAIN_W-1:0]   proc_gain_ff;
   logic [smsf_pkg::NPROC_W-1:0]  proc_sources_ff;
   logic [smsf_pkg::GAIN_W-1:0]   mic_gain_sat;
   logic [smsf_pkg::GAIN_W-1:0]   proc_gain_sat;
   logic [SRC_W-1:0]              nproc;
   logic [1:0]                    reg_idx;
   logic                          reg_write;

   logic                          in_ready;
   logic                          out_free;
   logic                          mem_we;
   logic [MEM_AW-1:0]             mem_waddr;
   logic [FRAME_W-1:0]            mem_wdata;
   logic                          mem_re;
   logic [MEM_AW-1:0]             mem_raddr;
   logic [FRAME_W-1:0]            mem_rdata;
   smsf_pkg::mac_ctrl_type        mac_ctrl;
   logic signed [SAMPLE_BITS-1:0] mac_sample;
   logic [smsf_pkg::GAIN_W-1:0]   mac_gain;
   logic signed [SAMPLE_BITS-1:0] mix_left;
   logic signed [SAMPLE_BITS-1:0] mix_right;
   smsf_pkg::result_type          result;

   logic                          rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]        out_left_ff;
   logic [SAMPLE_BITS-1:0]        out_right_ff;
   logic                          dropped_ff;
   logic                          underrun_ff;
   logic [smsf_pkg::DROP_W-1:0]   drop_total_ff;

   // Register writes
   assign pready = 1'b1;
   assign reg_idx = paddr[3:2];
   assign reg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mic_gain_ff <= smsf_pkg::GAIN_UNITY;
         proc_gain_ff <= smsf_pkg::GAIN_UNITY;
         proc_sources_ff <= '0;
      end else if (reg_write) begin
         unique case (reg_idx)
            smsf_pkg::REG_MIC_GAIN:     mic_gain_ff <= pwdata[smsf_pkg::GAIN_W-1:0];
            smsf_pkg::REG_PROC_GAIN:    proc_gain_ff <= pwdata[smsf_pkg::GAIN_W-1:0];
            smsf_pkg::REG_PROC_SOURCES: proc_sources_ff <= pwdata[smsf_pkg::NPROC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (reg_idx)
         smsf_pkg::REG_MIC_GAIN:     prdata = smsf_pkg::CSR_DATA_W'(mic_gain_ff);
         smsf_pkg::REG_PROC_GAIN:    prdata = smsf_pkg::CSR_DATA_W'(proc_gain_ff);
         smsf_pkg::REG_PROC_SOURCES: prdata = smsf_pkg::CSR_DATA_W'(proc_sources_ff);
         default:                    prdata = '0;
      endcase
   end

   // Limit gains to 2.0 and the process count to the sources built
   assign mic_gain_sat = (mic_gain_ff > smsf_pkg::GAIN_MAX) ? smsf_pkg::GAIN_MAX : mic_gain_ff;
   assign proc_gain_sat = (proc_gain_ff > smsf_pkg::GAIN_MAX) ? smsf_pkg::GAIN_MAX
                                                               : proc_gain_ff;
   assign nproc = (32'(proc_sources_ff) > NUM_SOURCES - 1) ? SRC_W'(NUM_SOURCES - 1)
                                                          : SRC_W'(proc_sources_ff);

   assign req_stall = !in_ready;

   smsf_seq #(
      .FIFO_DEPTH  (FIFO_DEPTH),
      .NUM_SOURCES (NUM_SOURCES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .in_ready     (in_ready),
      .req_cmd      (req_cmd),
      .req_source   (req_source),
      .req_in_left  (req_in_left),
      .req_in_right (req_in_right),
      .nproc        (nproc),
      .mic_gain     (mic_gain_sat),
      .proc_gain    (proc_gain_sat),
      .out_free     (out_free),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_re       (mem_re),
      .mem_raddr    (mem_raddr),
      .mem_rdata    (mem_rdata),
      .mac_ctrl     (mac_ctrl),
      .mac_sample   (mac_sample),
      .mac_gain     (mac_gain),
      .result       (result)
   );

   smsf_frame_store #(
      .ADDR_W (MEM_AW),
      .DATA_W (FRAME_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   smsf_mac #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SRC_W       (SRC_W)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mac_ctrl),
      .sample    (mac_sample),
      .gain      (mac_gain),
      .mix_left  (mix_left),
      .mix_right (mix_right)
   );

   // Output register: load a finished beat, drop valid once taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.load) begin
         out_left_ff <= result.is_pull ? mix_left : '0;
         out_right_ff <= result.is_pull ? mix_right : '0;
         dropped_ff <= result.dropped;
         underrun_ff <= result.underrun;
         drop_total_ff <= result.total;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_left = out_left_ff;
   assign rsp_out_right = out_right_ff;
   assign rsp_dropped = dropped_ff;
   assign rsp_underrun = underrun_ff;
   assign rsp_drop_total = drop_total_ff;

endmodule
